FILE: hdl/vsl_pkg.sv
package vsl_pkg;

  // fixed field formats
  localparam int COMP_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int EPS_W      = 12;
  localparam int FRAC_BITS  = 12;
  localparam int Q_BITS     = 30;

  localparam logic [EPS_W-1:0]    EPS_RESET  = 12'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;

  // cordic datapath
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int ATAN_LEN          = 32;
  localparam int CORDIC_W          = 34;

  localparam logic [CORDIC_W-1:0] ONE_Q30     = 34'd1073741824;
  localparam logic [CORDIC_W-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [CORDIC_W-1:0] HALF_PI_Q30 = 34'd1686629713;

  // ratio coefficients are capped to this many bits
  localparam int RATIO_W = 62 - COMP_W;

  // sideband that travels with each request through the long units
  typedef struct packed {
    logic                          valid;
    logic                          lin;
    logic                          negdot;
    logic                          flag;
    logic [31:0]                   aux;
    logic [2:0][COMP_W-1:0]        a;
    logic [2:0][COMP_W-1:0]        b;
    logic [WEIGHT_W-1:0]           t;
  } vsl_side_t;

  // atan(2^-i) in q30, truncated
  function automatic logic [31:0] atan_q30(input int i);
    case (i)
      0:       atan_q30 = 32'd843314856;
      1:       atan_q30 = 32'd497837829;
      2:       atan_q30 = 32'd263043836;
      3:       atan_q30 = 32'd133525158;
      4:       atan_q30 = 32'd67021686;
      5:       atan_q30 = 32'd33543515;
      6:       atan_q30 = 32'd16775850;
      7:       atan_q30 = 32'd8388437;
      8:       atan_q30 = 32'd4194282;
      9:       atan_q30 = 32'd2097149;
      10:      atan_q30 = 32'd1048575;
      11:      atan_q30 = 32'd524287;
      12:      atan_q30 = 32'd262143;
      13:      atan_q30 = 32'd131071;
      14:      atan_q30 = 32'd65535;
      15:      atan_q30 = 32'd32767;
      16:      atan_q30 = 32'd16383;
      17:      atan_q30 = 32'd8191;
      18:      atan_q30 = 32'd4095;
      19:      atan_q30 = 32'd2047;
      20:      atan_q30 = 32'd1023;
      21:      atan_q30 = 32'd511;
      22:      atan_q30 = 32'd255;
      23:      atan_q30 = 32'd127;
      24:      atan_q30 = 32'd63;
      25:      atan_q30 = 32'd31;
      26:      atan_q30 = 32'd15;
      27:      atan_q30 = 32'd7;
      28:      atan_q30 = 32'd3;
      29:      atan_q30 = 32'd1;
      default: atan_q30 = 32'd0;
    endcase
  endfunction

endpackage

FILE: hdl/vsl_sqrt.sv
module vsl_sqrt #(
  parameter int OW = 32
) (
  input  logic            clk_i,
  input  logic [2*OW-1:0] v_i,
  output logic [OW-1:0]   root_o
);

  localparam int RW = OW + 3;

  logic [RW-1:0]   rem_in  [OW];
  logic [OW-1:0]   root_in [OW];
  logic [2*OW-1:0] v_in    [OW];
  logic [RW-1:0]   rem_d   [OW];
  logic [OW-1:0]   root_d  [OW];
  logic [2*OW-1:0] v_d     [OW];
  logic [RW-1:0]   rem_q   [OW];
  logic [OW-1:0]   root_q  [OW];
  logic [2*OW-1:0] v_q     [OW];
  logic [RW-1:0]   cur_w   [OW];
  logic [RW-1:0]   trial_w [OW];

  // stage inputs: first stage from the port, the rest from the previous stage
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    v_in[0]    = v_i;
    for (int k = 1; k < OW; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      v_in[k]    = v_q[k-1];
    end
  end

  // one root bit per stage, two radicand bits shifted in
  always_comb begin
    for (int k = 0; k < OW; k++) begin
      cur_w[k]   = {rem_in[k][RW-3:0], v_in[k][2*OW-1 -: 2]};
      trial_w[k] = {1'b0, root_in[k], 2'b01};
      v_d[k]     = v_in[k] << 2;
      if (cur_w[k] >= trial_w[k]) begin
        rem_d[k]  = cur_w[k] - trial_w[k];
        root_d[k] = {root_in[k][OW-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur_w[k];
        root_d[k] = {root_in[k][OW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < OW; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      v_q[k]    <= v_d[k];
    end
  end

  assign root_o = root_q[OW-1];

endmodule

FILE: hdl/vsl_div.sv
module vsl_div #(
  parameter int NW = 62,
  parameter int DW = 32,
  parameter int QW = 30
) (
  input  logic          clk_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_in [QW];
  logic [QW-1:0] lo_in  [QW];
  logic [QW-1:0] q_in   [QW];
  logic [DW-1:0] d_in   [QW];
  logic [DW-1:0] rem_d  [QW];
  logic [QW-1:0] lo_d   [QW];
  logic [QW-1:0] q_d    [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [QW-1:0] q_q    [QW];
  logic [DW-1:0] d_q    [QW];
  logic [DW:0]   cur_w  [QW];

  // high part of the numerator is below the divisor by construction
  always_comb begin
    rem_in[0] = DW'(n_i >> QW);
    lo_in[0]  = n_i[QW-1:0];
    q_in[0]   = '0;
    d_in[0]   = d_i;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem_q[k-1];
      lo_in[k]  = lo_q[k-1];
      q_in[k]   = q_q[k-1];
      d_in[k]   = d_q[k-1];
    end
  end

  // restoring step, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      cur_w[k] = {rem_in[k], lo_in[k][QW-1]};
      lo_d[k]  = lo_in[k] << 1;
      if (cur_w[k] >= {1'b0, d_in[k]}) begin
        rem_d[k] = DW'(cur_w[k] - {1'b0, d_in[k]});
        q_d[k]   = {q_in[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = DW'(cur_w[k]);
        q_d[k]   = {q_in[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rem_q[k] <= rem_d[k];
      lo_q[k]  <= lo_d[k];
      q_q[k]   <= q_d[k];
      d_q[k]   <= d_in[k];
    end
  end

  assign q_o = q_q[QW-1];

endmodule

FILE: hdl/vsl_cordic.sv
module vsl_cordic import vsl_pkg::*; #(
  parameter int STAGES    = DEF_CORDIC_STAGES,
  parameter bit VECTORING = 1'b0
) (
  input  logic                       clk_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  input  logic signed [CORDIC_W-1:0] z_i,
  output logic signed [CORDIC_W-1:0] y_o,
  output logic signed [CORDIC_W-1:0] z_o
);

  logic signed [CORDIC_W-1:0] x_in [STAGES];
  logic signed [CORDIC_W-1:0] y_in [STAGES];
  logic signed [CORDIC_W-1:0] z_in [STAGES];
  logic signed [CORDIC_W-1:0] x_d  [STAGES];
  logic signed [CORDIC_W-1:0] y_d  [STAGES];
  logic signed [CORDIC_W-1:0] z_d  [STAGES];
  logic signed [CORDIC_W-1:0] x_q  [STAGES];
  logic signed [CORDIC_W-1:0] y_q  [STAGES];
  logic signed [CORDIC_W-1:0] z_q  [STAGES];
  logic signed [CORDIC_W-1:0] dx_w [STAGES];
  logic signed [CORDIC_W-1:0] dy_w [STAGES];
  logic signed [CORDIC_W-1:0] at_w [STAGES];
  logic                       neg_w [STAGES];

  always_comb begin
    x_in[0] = x_i;
    y_in[0] = y_i;
    z_in[0] = z_i;
    for (int k = 1; k < STAGES; k++) begin
      x_in[k] = x_q[k-1];
      y_in[k] = y_q[k-1];
      z_in[k] = z_q[k-1];
    end
  end

  // micro-rotation: vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      dx_w[k]  = y_in[k] >>> k;
      dy_w[k]  = x_in[k] >>> k;
      at_w[k]  = $signed(CORDIC_W'(atan_q30(k)));
      neg_w[k] = VECTORING ? (y_in[k] > 0) : (z_in[k] < 0);
      if (neg_w[k]) begin
        x_d[k] = x_in[k] + dx_w[k];
        y_d[k] = y_in[k] - dy_w[k];
        z_d[k] = z_in[k] + at_w[k];
      end else begin
        x_d[k] = x_in[k] - dx_w[k];
        y_d[k] = y_in[k] + dy_w[k];
        z_d[k] = z_in[k] - at_w[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STAGES; k++) begin
      x_q[k] <= x_d[k];
      y_q[k] <= y_d[k];
      z_q[k] <= z_d[k];
    end
  end

  assign y_o = y_q[STAGES-1];
  assign z_o = z_q[STAGES-1];

endmodule

FILE: hdl/vector_slerp_unit.sv
// Spherical linear interpolation of two 3D vectors, one request per clock.
// Request channel: drive a_*_i, b_*_i (signed Q4.12) and weight_i (Q1.15, 32768
// is one) with start high; it is taken at any rising edge where busy is low.
// busy is always low: the datapath is a fixed pipeline that takes a new
// request in every cycle.
// Result channel: done_o is high for one cycle with r_*_o and used_linear_o;
// the receiver cannot hold results off and none are needed to be held.
// The datapath holds the two 32/31-step square roots, the 30-step and 47-step
// dividers and the two CORDIC chains, one bit or one rotation per stage.
// Throughput is one result per cycle; results leave in request order.
// Configuration: cfg_we_i writes epsilon from cfg_wdata_i; write it only while
// no request is in flight. Reset sets epsilon to one and clears all valid bits,
// so no result is produced until a request follows reset.
module vector_slerp_unit import vsl_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we_i,
  input  logic [EPS_W-1:0]         cfg_wdata_i,
  input  logic signed [COMP_W-1:0] a_x_i,
  input  logic signed [COMP_W-1:0] a_y_i,
  input  logic signed [COMP_W-1:0] a_z_i,
  input  logic signed [COMP_W-1:0] b_x_i,
  input  logic signed [COMP_W-1:0] b_y_i,
  input  logic signed [COMP_W-1:0] b_z_i,
  input  logic [WEIGHT_W-1:0]      weight_i,
  output logic                     done_o,
  output logic signed [COMP_W-1:0] r_x_o,
  output logic signed [COMP_W-1:0] r_y_o,
  output logic signed [COMP_W-1:0] r_z_o,
  output logic                     used_linear_o
);

  localparam int SQ1_OW  = 32;
  localparam int DIV1_QW = 30;
  localparam int SQ2_OW  = 31;
  localparam int SIN_W   = 31;
  localparam int DIV2_QW = RATIO_W + 1;
  localparam int LO_W    = RATIO_W / 2;
  localparam int HI_W    = RATIO_W - LO_W;
  localparam int PROD_W  = COMP_W + HI_W + 1;
  localparam int LIN_W   = 2 * COMP_W + 2;

  localparam logic signed [63:0] SAT_HI = 64'sd32767;
  localparam logic signed [63:0] SAT_LO = -64'sd32768;

  function automatic logic signed [CORDIC_W-1:0] fold_arg(input logic [31:0] g);
    logic [CORDIC_W-1:0] gz;
    gz = CORDIC_W'(g);
    if (gz > HALF_PI_Q30) fold_arg = $signed(PI_Q30 - gz);
    else fold_arg = $signed(gz);
  endfunction

  function automatic logic [COMP_W-1:0] sat_comp(input logic signed [63:0] v);
    if (v > SAT_HI) sat_comp = SAT_HI[COMP_W-1:0];
    else if (v < SAT_LO) sat_comp = SAT_LO[COMP_W-1:0];
    else sat_comp = v[COMP_W-1:0];
  endfunction

  assign busy = 1'b0;

  // epsilon register and its square
  logic [EPS_W-1:0]   eps_q;
  logic [2*EPS_W-1:0] eps2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= EPS_RESET;
      eps2_q <= (2*EPS_W)'(EPS_RESET) * (2*EPS_W)'(EPS_RESET);
    end else if (cfg_we_i) begin
      eps_q  <= cfg_wdata_i;
      eps2_q <= cfg_wdata_i * cfg_wdata_i;
    end
  end

  // stage 1: request capture and component products
  vsl_side_t                 p1_d, p1_q;
  logic [2:0][31:0]          aa_d, bb_d, ab_d, aa_q, bb_q, ab_q;

  always_comb begin
    p1_d        = '0;
    p1_d.valid  = start;
    p1_d.a      = {a_z_i, a_y_i, a_x_i};
    p1_d.b      = {b_z_i, b_y_i, b_x_i};
    p1_d.t      = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
    for (int k = 0; k < 3; k++) begin
      aa_d[k] = $signed(p1_d.a[k]) * $signed(p1_d.a[k]);
      bb_d[k] = $signed(p1_d.b[k]) * $signed(p1_d.b[k]);
      ab_d[k] = $signed(p1_d.a[k]) * $signed(p1_d.b[k]);
    end
  end

  // stage 2: squared lengths, dot product, length test
  vsl_side_t         p2_d, p2_q;
  logic [31:0]       la2_d, lb2_d, la2_q, lb2_q;
  logic signed [33:0] dot_w;

  always_comb begin
    p2_d       = p1_q;
    la2_d      = aa_q[0] + aa_q[1] + aa_q[2];
    lb2_d      = bb_q[0] + bb_q[1] + bb_q[2];
    dot_w      = 34'($signed(ab_q[0])) + 34'($signed(ab_q[1])) + 34'($signed(ab_q[2]));
    p2_d.negdot = dot_w[33];
    p2_d.aux   = dot_w[33] ? 32'(-dot_w) : 32'(dot_w);
    p2_d.lin   = (la2_d < 32'(eps2_q)) || (lb2_d < 32'(eps2_q));
  end

  // stage 3: length product for the denominator root
  vsl_side_t   p3_q;
  logic [63:0] lprod_q;

  // square root of the length product
  logic [SQ1_OW-1:0] den_w;
  vsl_side_t         sq1_q [SQ1_OW];

  vsl_sqrt #(.OW(SQ1_OW)) u_sqrt_den (
    .clk_i  (clk_i),
    .v_i    (lprod_q),
    .root_o (den_w)
  );

  // cosine quotient, saturated at one when the dot reaches the root
  vsl_side_t          p4_w;
  logic [DIV1_QW-1:0] cq_w;
  vsl_side_t          dv1_q [DIV1_QW];

  always_comb begin
    p4_w      = sq1_q[SQ1_OW-1];
    p4_w.lin  = p4_w.lin || (den_w == '0);
    p4_w.flag = (p4_w.aux >= den_w);
  end

  vsl_div #(.NW(62), .DW(SQ1_OW), .QW(DIV1_QW)) u_div_cos (
    .clk_i (clk_i),
    .n_i   ({p4_w.aux, 30'd0}),
    .d_i   (den_w),
    .q_o   (cq_w)
  );

  // stages 5 to 7: clamp cosine, square, one minus square
  vsl_side_t   p5_d, p5_q, p6_q, p7_q;
  logic [61:0] csq_q, v2_q;

  always_comb begin
    p5_d     = dv1_q[DIV1_QW-1];
    p5_d.aux = p5_d.flag ? 32'(ONE_Q30) : 32'(cq_w);
  end

  // sine of theta from the cosine
  logic [SQ2_OW-1:0] sn_w;
  vsl_side_t         sq2_q [SQ2_OW];

  vsl_sqrt #(.OW(SQ2_OW)) u_sqrt_sin (
    .clk_i  (clk_i),
    .v_i    (v2_q),
    .root_o (sn_w)
  );

  // stage 8: quadrant fold into the right half plane
  vsl_side_t                  p8_q;
  logic signed [CORDIC_W-1:0] ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic [SQ2_OW-1:0]          cm_w;

  always_comb begin
    cm_w = sq2_q[SQ2_OW-1].aux[SQ2_OW-1:0];
    if (sq2_q[SQ2_OW-1].negdot && (cm_w != '0)) begin
      ax_d = $signed(CORDIC_W'(sn_w));
      ay_d = $signed(CORDIC_W'(cm_w));
      az_d = $signed(HALF_PI_Q30);
    end else begin
      ax_d = $signed(CORDIC_W'(cm_w));
      ay_d = $signed(CORDIC_W'(sn_w));
      az_d = '0;
    end
  end

  // angle cordic
  logic signed [CORDIC_W-1:0] ang_w;
  vsl_side_t                  ca_q [CORDIC_STAGES];

  vsl_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_cordic_ang (
    .clk_i (clk_i),
    .x_i   (ax_q),
    .y_i   (ay_q),
    .z_i   (az_q),
    .y_o   (),
    .z_o   (ang_w)
  );

  // stage 9: clamp theta to [0, pi]
  vsl_side_t   p9_q;
  logic [31:0] th_d, th_q;

  always_comb begin
    if (ang_w < 0) th_d = '0;
    else if (ang_w > $signed(PI_Q30)) th_d = PI_Q30[31:0];
    else th_d = ang_w[31:0];
  end

  // stage 10: small angle test and weighted angle
  vsl_side_t   p10_d, p10_q;
  logic [47:0] tprod_w;
  logic [31:0] th10_q, ph2_q;

  always_comb begin
    p10_d     = p9_q;
    p10_d.lin = p9_q.lin || (th_q < 32'({eps_q, 18'd0}));
    tprod_w   = th_q * p9_q.t;
  end

  // stage 11: sine arguments folded below pi/2
  vsl_side_t                  p11_q;
  logic signed [CORDIC_W-1:0] phi_q [3];

  // sine cordics: theta, (1-t)theta, t theta
  logic signed [CORDIC_W-1:0] sy_w [3];
  vsl_side_t                  cs_q [CORDIC_STAGES];

  for (genvar g = 0; g < 3; g++) begin : g_sin
    vsl_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_cordic_sin (
      .clk_i (clk_i),
      .x_i   ($signed(ONE_Q30)),
      .y_i   ('0),
      .z_i   (phi_q[g]),
      .y_o   (sy_w[g]),
      .z_o   ()
    );
  end

  // stage 12: clamp sines, zero sine test, ratio overflow test
  vsl_side_t          p12_d, p12_q;
  logic [SIN_W-1:0]   sn_d [3];
  logic [SIN_W-1:0]   sn_q [3];

  always_comb begin
    p12_d = cs_q[CORDIC_STAGES-1];
    for (int k = 0; k < 3; k++) begin
      sn_d[k] = sy_w[k][CORDIC_W-1] ? '0 : sy_w[k][SIN_W-1:0];
    end
    p12_d.lin    = p12_d.lin || (sn_d[0] == '0);
    p12_d.aux    = '0;
    p12_d.aux[0] = (sn_d[1] >> 17) >= sn_d[0];
    p12_d.aux[1] = (sn_d[2] >> 17) >= sn_d[0];
  end

  // ratio dividers
  logic [DIV2_QW-1:0] q1_w, q2_w;
  vsl_side_t          dv2_q [DIV2_QW];

  vsl_div #(.NW(SIN_W + Q_BITS), .DW(SIN_W), .QW(DIV2_QW)) u_div_c1 (
    .clk_i (clk_i),
    .n_i   ({sn_q[1], 30'd0}),
    .d_i   (sn_q[0]),
    .q_o   (q1_w)
  );

  vsl_div #(.NW(SIN_W + Q_BITS), .DW(SIN_W), .QW(DIV2_QW)) u_div_c2 (
    .clk_i (clk_i),
    .n_i   ({sn_q[2], 30'd0}),
    .d_i   (sn_q[0]),
    .q_o   (q2_w)
  );

  // stage 13: cap the coefficients
  vsl_side_t          p13_q;
  logic [RATIO_W-1:0] c1_d, c2_d, c1_q, c2_q;

  always_comb begin
    c1_d = (dv2_q[DIV2_QW-1].aux[0] || q1_w[RATIO_W]) ? '1 : q1_w[RATIO_W-1:0];
    c2_d = (dv2_q[DIV2_QW-1].aux[1] || q2_w[RATIO_W]) ? '1 : q2_w[RATIO_W-1:0];
  end

  // stage 14: partial products for both blends
  vsl_side_t                p14_q;
  logic signed [PROD_W-1:0] alo_d [3], ahi_d [3], blo_d [3], bhi_d [3];
  logic signed [PROD_W-1:0] alo_q [3], ahi_q [3], blo_q [3], bhi_q [3];
  logic signed [LIN_W-1:0]  lp_d [3], lp_q [3];
  logic signed [COMP_W:0]   df_w [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      alo_d[k] = $signed(p13_q.a[k]) * $signed({1'b0, c1_q[LO_W-1:0]});
      ahi_d[k] = $signed(p13_q.a[k]) * $signed({1'b0, c1_q[RATIO_W-1:LO_W]});
      blo_d[k] = $signed(p13_q.b[k]) * $signed({1'b0, c2_q[LO_W-1:0]});
      bhi_d[k] = $signed(p13_q.b[k]) * $signed({1'b0, c2_q[RATIO_W-1:LO_W]});
      df_w[k]  = (COMP_W+1)'($signed(p13_q.b[k])) - (COMP_W+1)'($signed(p13_q.a[k]));
      lp_d[k]  = df_w[k] * $signed({1'b0, p13_q.t});
    end
  end

  // stage 15: sum, round, saturate, select
  logic [2:0][COMP_W-1:0]  r_d, r_q;
  logic signed [63:0]      sl_w [3];
  logic signed [63:0]      ln_w [3];
  logic                    done_q, lin_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sl_w[k] = ((64'(ahi_q[k]) <<< LO_W) + 64'(alo_q[k]) + (64'(bhi_q[k]) <<< LO_W)
                 + 64'(blo_q[k]) + (64'sd1 <<< 29)) >>> 30;
      ln_w[k] = 64'($signed(p14_q.a[k])) + ((64'(lp_q[k]) + (64'sd1 <<< 14)) >>> 15);
      r_d[k]  = p14_q.lin ? sat_comp(ln_w[k]) : sat_comp(sl_w[k]);
    end
  end

  // control registers: stage sidebands and delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= '0;
      p5_q   <= '0;
      p6_q   <= '0;
      p7_q   <= '0;
      p8_q   <= '0;
      p9_q   <= '0;
      p10_q  <= '0;
      p11_q  <= '0;
      p12_q  <= '0;
      p13_q  <= '0;
      p14_q  <= '0;
      done_q <= 1'b0;
      lin_q  <= 1'b0;
      for (int k = 0; k < SQ1_OW; k++) sq1_q[k] <= '0;
      for (int k = 0; k < DIV1_QW; k++) dv1_q[k] <= '0;
      for (int k = 0; k < SQ2_OW; k++) sq2_q[k] <= '0;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        ca_q[k] <= '0;
        cs_q[k] <= '0;
      end
      for (int k = 0; k < DIV2_QW; k++) dv2_q[k] <= '0;
    end else begin
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      p3_q     <= p2_q;
      sq1_q[0] <= p3_q;
      for (int k = 1; k < SQ1_OW; k++) sq1_q[k] <= sq1_q[k-1];
      dv1_q[0] <= p4_w;
      for (int k = 1; k < DIV1_QW; k++) dv1_q[k] <= dv1_q[k-1];
      p5_q     <= p5_d;
      p6_q     <= p5_q;
      p7_q     <= p6_q;
      sq2_q[0] <= p7_q;
      for (int k = 1; k < SQ2_OW; k++) sq2_q[k] <= sq2_q[k-1];
      p8_q     <= sq2_q[SQ2_OW-1];
      ca_q[0]  <= p8_q;
      for (int k = 1; k < CORDIC_STAGES; k++) ca_q[k] <= ca_q[k-1];
      p9_q     <= ca_q[CORDIC_STAGES-1];
      p10_q    <= p10_d;
      p11_q    <= p10_q;
      cs_q[0]  <= p11_q;
      for (int k = 1; k < CORDIC_STAGES; k++) cs_q[k] <= cs_q[k-1];
      p12_q    <= p12_d;
      dv2_q[0] <= p12_q;
      for (int k = 1; k < DIV2_QW; k++) dv2_q[k] <= dv2_q[k-1];
      p13_q    <= dv2_q[DIV2_QW-1];
      p14_q    <= p13_q;
      done_q   <= p14_q.valid;
      lin_q    <= p14_q.lin;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    aa_q    <= aa_d;
    bb_q    <= bb_d;
    ab_q    <= ab_d;
    la2_q   <= la2_d;
    lb2_q   <= lb2_d;
    lprod_q <= la2_q * lb2_q;
    csq_q   <= p5_q.aux[30:0] * p5_q.aux[30:0];
    v2_q    <= (62'd1 << 60) - csq_q;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    th_q    <= th_d;
    th10_q  <= th_q;
    ph2_q   <= tprod_w[46:15];
    phi_q[0] <= fold_arg(th10_q);
    phi_q[1] <= fold_arg(th10_q - ph2_q);
    phi_q[2] <= fold_arg(ph2_q);
    for (int k = 0; k < 3; k++) begin
      sn_q[k]  <= sn_d[k];
      alo_q[k] <= alo_d[k];
      ahi_q[k] <= ahi_d[k];
      blo_q[k] <= blo_d[k];
      bhi_q[k] <= bhi_d[k];
      lp_q[k]  <= lp_d[k];
    end
    c1_q <= c1_d;
    c2_q <= c2_d;
    r_q  <= r_d;
  end

  assign done_o        = done_q;
  assign used_linear_o = lin_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];

endmodule

FILE: tb/slerp_checker.sv
`timescale 1ns / 1ps

module slerp_checker import vsl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic                     cfg_we_i,
  input  logic [EPS_W-1:0]         cfg_wdata_i,
  input  logic signed [COMP_W-1:0] a_x_i,
  input  logic signed [COMP_W-1:0] a_y_i,
  input  logic signed [COMP_W-1:0] a_z_i,
  input  logic signed [COMP_W-1:0] b_x_i,
  input  logic signed [COMP_W-1:0] b_y_i,
  input  logic signed [COMP_W-1:0] b_z_i,
  input  logic [WEIGHT_W-1:0]      weight_i,
  input  logic                     done_i,
  input  logic signed [COMP_W-1:0] r_x_i,
  input  logic signed [COMP_W-1:0] r_y_i,
  input  logic signed [COMP_W-1:0] r_z_i,
  input  logic                     used_linear_i,
  output int                       errors_o,
  output int                       pending_o
);

  localparam int STAGES = DEF_CORDIC_STAGES;

  typedef struct {
    logic signed [COMP_W-1:0] r [3];
    logic                     lin;
  } slerp_res_t;

  slerp_res_t     interp_q [$];
  logic [EPS_W-1:0] eps_q;

  // integer square root, floored
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // vectoring cordic: angle of (c, s) in q30 radians
  function automatic longint angle_of(longint c, longint s);
    longint x, y, z, dx, dy;
    if (c < 0) begin
      x = s; y = -c; z = longint'(HALF_PI_Q30);
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
    return z;
  endfunction

  // rotation cordic sine with gain left in, arg in [0, pi]
  function automatic longint gain_sine(longint phi);
    longint x, y, z, dx, dy;
    if (phi > longint'(HALF_PI_Q30)) phi = longint'(PI_Q30) - phi;
    if (phi < 0) phi = 0;
    x = longint'(ONE_Q30);
    y = 0;
    z = phi;
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
      end
    end
    return (y < 0) ? 0 : y;
  endfunction

  function automatic longint coef_ratio(longint num, longint den);
    longint unsigned cap, q;
    cap = (64'd1 << RATIO_W) - 1;
    q   = (longint'(num) << 30) / longint'(den);
    return longint'((q > cap) ? cap : q);
  endfunction

  function automatic logic signed [COMP_W-1:0] sat_comp(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COMP_W-1:0];
  endfunction

  function automatic slerp_res_t predict_slerp(longint av [3], longint bv [3],
                                               longint unsigned tw,
                                               longint unsigned eps);
    slerp_res_t      res;
    longint unsigned la2, lb2, pos, neg, eps2, m, mag, den, cm;
    longint          c, sn, theta, ph2, sin_t, c1, c2, p, r;
    int              s;
    logic            lin, negdot;
    la2 = 0; lb2 = 0; pos = 0; neg = 0;
    c1 = 0; c2 = 0;
    lin = 1'b0;
    eps2 = eps * eps;
    for (int k = 0; k < 3; k++) begin
      la2 = la2 + longint'(av[k] * av[k]);
      lb2 = lb2 + longint'(bv[k] * bv[k]);
      p = av[k] * bv[k];
      if (p >= 0) pos = pos + p;
      else        neg = neg + (-p);
    end
    if (tw > 32768) tw = 32768;
    if (la2 < eps2 || lb2 < eps2) begin
      lin = 1'b1;
    end else begin
      m = (la2 > lb2) ? la2 : lb2;
      negdot = neg > pos;
      mag = negdot ? neg - pos : pos - neg;
      s = 0;
      while (((m >> s) >> 32) != 0) s++;
      den = root_floor((la2 >> s) * (lb2 >> s));
      if (den == 0) begin
        lin = 1'b1;
      end else begin
        cm = ((mag >> s) << 30) / den;
        if (cm > (64'd1 << 30)) cm = 64'd1 << 30;
        c = negdot ? -longint'(cm) : longint'(cm);
        sn = longint'(root_floor((64'd1 << 60) - longint'(c * c)));
        theta = angle_of(c, sn);
        if (theta < longint'(eps << (30 - FRAC_BITS))) begin
          lin = 1'b1;
        end else begin
          sin_t = gain_sine(theta);
          if (sin_t <= 0) begin
            lin = 1'b1;
          end else begin
            ph2 = longint'((longint'(theta) * tw) >> 15);
            c1 = coef_ratio(gain_sine(theta - ph2), sin_t);
            c2 = coef_ratio(gain_sine(ph2), sin_t);
          end
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (lin) r = av[k] + (((bv[k] - av[k]) * longint'(tw) + (64'sd1 <<< 14)) >>> 15);
      else     r = (av[k] * c1 + bv[k] * c2 + (64'sd1 <<< 29)) >>> 30;
      res.r[k] = sat_comp(r);
    end
    res.lin = lin;
    return res;
  endfunction

  assign pending_o = interp_q.size();

  // epsilon shadow and request capture
  always @(posedge clk_i or negedge rst_ni) begin
    longint av [3];
    longint bv [3];
    if (!rst_ni) begin
      eps_q = EPS_RESET;
    end else begin
      if (start_i && !busy_i) begin
        av[0] = a_x_i; av[1] = a_y_i; av[2] = a_z_i;
        bv[0] = b_x_i; bv[1] = b_y_i; bv[2] = b_z_i;
        interp_q.push_back(predict_slerp(av, bv, weight_i, eps_q));
      end
      if (cfg_we_i) eps_q = cfg_wdata_i;
    end
  end

  // result compare against oldest expectation
  always @(posedge clk_i) begin
    slerp_res_t exp_r;
    if (!rst_ni) begin
      errors_o = 0;
    end else if (done_i) begin
      if (interp_q.size() == 0) begin
        $display("%0t: unexpected result r=(%0d,%0d,%0d) lin=%0b", $time,
                 r_x_i, r_y_i, r_z_i, used_linear_i);
        errors_o = errors_o + 1;
      end else begin
        exp_r = interp_q.pop_front();
        if (exp_r.r[0] !== r_x_i || exp_r.r[1] !== r_y_i || exp_r.r[2] !== r_z_i ||
            exp_r.lin !== used_linear_i) begin
          $display("%0t: mismatch expected (%0d,%0d,%0d) lin=%0b actual (%0d,%0d,%0d) lin=%0b",
                   $time, exp_r.r[0], exp_r.r[1], exp_r.r[2], exp_r.lin,
                   r_x_i, r_y_i, r_z_i, used_linear_i);
          errors_o = errors_o + 1;
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import vsl_pkg::*;

  localparam int LATENCY   = 154 + 2 * DEF_CORDIC_STAGES;
  localparam int MAX_CYCLE = 600000;

  logic clk_i, rst_ni, start, busy, cfg_we_i, done_o, used_linear_o;
  logic [EPS_W-1:0] cfg_wdata_i;
  logic signed [COMP_W-1:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i;
  logic signed [COMP_W-1:0] r_x_o, r_y_o, r_z_o;
  logic [WEIGHT_W-1:0] weight_i;
  int errors, pending, cycles;
  int idle_pct;

  vector_slerp_unit uut (.*);

  slerp_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cfg_we_i, .cfg_wdata_i,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .weight_i,
    .done_i(done_o), .r_x_i(r_x_o), .r_y_i(r_y_o), .r_z_i(r_z_o),
    .used_linear_i(used_linear_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > MAX_CYCLE) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // issue one request, then maybe idle
  task automatic send_vec(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                          logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                          logic [15:0] w);
    a_x_i <= ax; a_y_i <= ay; a_z_i <= az;
    b_x_i <= bx; b_y_i <= by; b_z_i <= bz;
    weight_i <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] near(logic [15:0] v, int spread);
    return v + 16'($urandom_range(2 * spread) - spread);
  endfunction

  // random request: mostly unit-scale vectors, some full range, tiny, near-aligned or near-opposite
  task automatic send_random();
    logic [15:0] v [6];
    logic [15:0] w;
    int mode;
    mode = $urandom_range(9);
    for (int k = 0; k < 6; k++) begin
      case (mode)
        0, 1:    v[k] = 16'($urandom);
        2:       v[k] = 16'($urandom_range(8) - 4);
        default: v[k] = 16'($urandom_range(16384) - 8192);
      endcase
    end
    if (mode == 7) for (int k = 0; k < 3; k++) v[k + 3] = near(v[k], 3);
    if (mode == 8) for (int k = 0; k < 3; k++) v[k + 3] = near(-v[k], 3);
    case ($urandom_range(7))
      0:       w = 16'd0;
      1:       w = WEIGHT_ONE;
      2:       w = 16'($urandom_range(65535, 32769));
      default: w = 16'($urandom_range(32768));
    endcase
    send_vec(v[0], v[1], v[2], v[3], v[4], v[5], w);
  endtask

  // drain and write epsilon while idle
  task automatic set_eps(logic [EPS_W-1:0] e);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_wdata_i <= e;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed_set();
    send_vec(0, 0, 0, 0, 0, 0, 16'd16384);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'd16384);
    send_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0);
    send_vec(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, WEIGHT_ONE);
    send_vec(4096, 0, 0, 0, 4096, 0, 16'd16384);
    send_vec(4096, 0, 0, 0, 4096, 0, 16'd0);
    send_vec(4096, 0, 0, 0, 4096, 0, WEIGHT_ONE);
    send_vec(4096, 0, 0, 0, 4096, 0, 16'hffff);
    send_vec(4096, 0, 0, 16'($signed(-4096)), 0, 0, 16'd16384);
    send_vec(4096, 0, 0, 8192, 0, 0, 16'd8192);
    send_vec(4096, 1, 0, 16'($signed(-4096)), 0, 0, 16'd16384);
    send_vec(4096, 0, 0, 16'($signed(-4096)), 1, 0, 16'd3000);
    send_vec(4096, 0, 0, 4096, 2, 0, 16'd20000);
    send_vec(0, 0, 0, 4096, 4096, 4096, 16'd16384);
    send_vec(1, 0, 0, 0, 1, 0, 16'd16384);
    send_vec(16'h7fff, 0, 0, 0, 16'h7fff, 0, 16'd16384);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe, 16'd16384);
    send_vec(3000, 4000, 0, 0, 16'($signed(-3000)), 4000, 16'd32767);
  endtask

  initial begin
    int eps_list [5];
    int idle_list [5];
    rst_ni = 1'b0; start = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    a_x_i = '0; a_y_i = '0; a_z_i = '0; b_x_i = '0; b_y_i = '0; b_z_i = '0;
    weight_i = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass under reset epsilon, then under zero
    directed_set();
    set_eps(0);
    directed_set();

    eps_list  = '{1, 4095, 0, 40, 300};
    idle_list = '{0, 87, 87, 32, 0};
    for (int ph = 0; ph < 5; ph++) begin
      set_eps(ph == 4 ? EPS_W'($urandom_range(4095)) : EPS_W'(eps_list[ph]));
      idle_pct = idle_list[ph];
      repeat (300) send_random();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: vector_slerp_unit.f
hdl/vsl_pkg.sv
hdl/vsl_sqrt.sv
hdl/vsl_div.sv
hdl/vsl_cordic.sv
hdl/vector_slerp_unit.sv
tb/slerp_checker.sv
tb/tb.sv
